FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMPLY(name, ck, rn, pre, post) \
    name: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error("implication failed");

// next-cycle implication, off while reset is low
`define ASSERT_NEXT(name, ck, rn, pre, post) \
    name: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error("next-cycle implication failed");

`endif

FILE: hw/rtl/ptst_pkg.sv
// ----------------------------------------------------------------------------
// ptst_pkg
// types, codes and sizes for the periodic task slot table
// ----------------------------------------------------------------------------
`default_nettype none

package ptst_pkg;

    localparam int SLOTS        = 10;
    localparam int TICK_MS      = 25;
    localparam int RUN_CAP      = 10;
    localparam int INTERVAL_MAX = 4095;

    localparam int OP_W     = 3;
    localparam int IDENT_W  = 16;
    localparam int HANDLE_W = 4;
    localparam int MSEC_W   = 16;
    localparam int STATUS_W = 2;
    localparam int IV_W     = 12;
    localparam int TICK_W   = 32;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    // reciprocal of the tick length, exact floor quotient for 16-bit periods
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = MSEC_W + RECIP_W;
    localparam logic [RECIP_W-1:0] TICK_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

    localparam logic [OP_W-1:0] OP_SCHEDULE   = 3'd0;
    localparam logic [OP_W-1:0] OP_RESCHEDULE = 3'd1;
    localparam logic [OP_W-1:0] OP_UNSCHEDULE = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL  = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK       = 3'd4;
    localparam logic [OP_W-1:0] OP_EXECUTE    = 3'd5;

    localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STS_MISMATCH = 2'd2;

    typedef struct packed {
        logic [IDENT_W-1:0] ident;
        logic [IV_W-1:0]    interval;
        logic [TICK_W-1:0]  deadline;
    } slot_entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/periodic_task_slot_table.sv
// ----------------------------------------------------------------------------
// periodic_task_slot_table
// cooperative periodic task scheduler kept as a slot memory
// ----------------------------------------------------------------------------
// requests arrive on s_axis: the opcode in tuser, identifier, handle and
// period in tdata. every request gives one response on m_axis, except execute,
// which gives one per due task with tlast on the final one, or one if none is due.
// slot identifier, interval and deadline live in a one-port-read ram; the
// used and due marks, the tick counter and the ready flag are flops.
// one request is in work at a time; s_axis_tready is high while idle, and
// the next request is taken the cycle after the last response is loaded.
// steps from request to response (output register free):
//   clear all, unknown opcodes, schedule on a full table, handle out of
//   range, execute with nothing due: emit; schedule: slot write, then emit;
//   reschedule, unschedule: slot read and check, then emit;
//   tick: each slot read, then compared and written back as the next is read;
//   execute: slots scanned in order, one response per due task found.
// a response waits in the output register while m_axis_tready is low;
// the next request is taken meanwhile and stalls only at its own response.
// reset empties all slots, clears the counter and the ready flag at once;
// no clearing pass runs, stale ram contents of empty slots are never used.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_slot_table (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // task_ident[15:0], slot_handle[19:16], period_msec[35:20], zero pad
    input  wire logic [ptst_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // opcode[2:0]
    input  wire logic [ptst_pkg::OP_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // status[1:0], result_slot[5:2], due_ident[21:6], ready_now[22], zero pad
    output logic [ptst_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // due_valid
    output logic                                m_axis_tuser,
    // last_of_run
    output logic                                m_axis_tlast
);

    import ptst_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCHED    = 3'd1;
    localparam logic [2:0] ST_CHECK    = 3'd2;
    localparam logic [2:0] ST_TICK     = 3'd3;
    localparam logic [2:0] ST_EXEC     = 3'd4;
    localparam logic [2:0] ST_EXEC_OUT = 3'd5;
    localparam logic [2:0] ST_EMIT     = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [OP_W-1:0]       op_reg;
    logic [IDENT_W-1:0]    ident_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [SLOT_W-1:0]     sel_reg, sel_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [SLOT_W-1:0]     chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic [CNT_W-1:0]      picks_reg, picks_next;
    logic [SLOTS-1:0]      used_reg, used_next;
    logic [SLOTS-1:0]      due_reg, due_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic                  ready_reg, ready_next;
    logic [STATUS_W-1:0]   pend_status_reg, pend_status_next;
    logic [HANDLE_W-1:0]   pend_slot_reg, pend_slot_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [HANDLE_W-1:0]   out_slot_reg;
    logic [IDENT_W-1:0]    out_ident_reg;
    logic                  out_dv_reg;
    logic                  out_ready_reg;
    logic                  out_last_reg;

    logic                  out_load;
    logic [STATUS_W-1:0]   res_status;
    logic [HANDLE_W-1:0]   res_slot;
    logic [IDENT_W-1:0]    res_ident;
    logic                  res_dv;
    logic                  res_last;

    logic                  ram_wr_en;
    logic [SLOT_W-1:0]     ram_wr_addr;
    slot_entry_t           ram_wr_data;
    logic [SLOT_W-1:0]     ram_rd_addr;
    slot_entry_t           ram_rd_data;

    logic                  accept;
    logic                  out_free;
    logic [IDENT_W-1:0]    in_ident;
    logic [HANDLE_W-1:0]   in_handle;
    logic [MSEC_W-1:0]     in_msec;
    logic [MSEC_W-1:0]     msec_clamped;
    logic [PROD_W-1:0]     prod_full;
    logic [PROD_W-RECIP_SHIFT-1:0] quot;
    logic [IV_W-1:0]       interval;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_idx;
    logic [SLOTS-1:0]      due_mask;
    logic [CNT_W-1:0]      due_total;
    logic [SLOT_W-1:0]     scan_idx;
    logic                  tick_hit;

    assign in_ident  = s_axis_tdata[15:0];
    assign in_handle = s_axis_tdata[19:16];
    assign in_msec   = s_axis_tdata[35:20];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // period to ticks through a reciprocal multiply, short periods count as one tick
    assign msec_clamped = (in_msec < MSEC_W'(TICK_MS)) ? MSEC_W'(TICK_MS) : in_msec;
    assign prod_full    = msec_clamped * TICK_RECIP;
    assign quot         = prod_reg[PROD_W-1:RECIP_SHIFT];
    assign interval     = (quot > (PROD_W-RECIP_SHIFT)'(INTERVAL_MAX))
                          ? IV_W'(INTERVAL_MAX) : quot[IV_W-1:0];

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign due_mask  = used_reg & due_reg;
    assign due_total = CNT_W'($countones(due_mask));
    assign scan_idx  = idx_reg[SLOT_W-1:0];
    assign tick_hit  = chk_valid_reg && used_reg[chk_idx_reg]
                       && (ram_rd_data.deadline == tick_reg);

    always_comb
    begin
        state_next       = state_reg;
        sel_next         = sel_reg;
        idx_next         = idx_reg;
        chk_valid_next   = 1'b0;
        chk_idx_next     = chk_idx_reg;
        n_next           = n_reg;
        picks_next       = picks_reg;
        used_next        = used_reg;
        due_next         = due_reg;
        tick_next        = tick_reg;
        ready_next       = ready_reg;
        pend_status_next = pend_status_reg;
        pend_slot_next   = pend_slot_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_load         = 1'b0;
        res_status       = STS_OK;
        res_slot         = '0;
        res_ident        = '0;
        res_dv           = 1'b0;
        res_last         = 1'b1;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = sel_reg;
        ram_wr_data      = '{ident: ident_reg, interval: interval,
                             deadline: tick_reg + TICK_W'(interval)};
        ram_rd_addr      = scan_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_rd_addr = in_handle[SLOT_W-1:0];
                if (accept)
                begin
                    pend_status_next = STS_OK;
                    pend_slot_next   = '0;
                    state_next       = ST_EMIT;
                    unique case (s_axis_tuser) inside
                        OP_SCHEDULE:
                        begin
                            if (free_found)
                            begin
                                sel_next   = free_idx;
                                state_next = ST_SCHED;
                            end
                            else
                            begin
                                pend_status_next = STS_FULL;
                            end
                        end
                        OP_RESCHEDULE, OP_UNSCHEDULE:
                        begin
                            if (int'(in_handle) >= SLOTS)
                            begin
                                pend_status_next = STS_FULL;
                                pend_slot_next   = in_handle;
                            end
                            else
                            begin
                                sel_next   = in_handle[SLOT_W-1:0];
                                state_next = ST_CHECK;
                            end
                        end
                        OP_CLEAR_ALL:
                        begin
                            used_next = '0;
                            due_next  = '0;
                        end
                        OP_TICK:
                        begin
                            tick_next  = tick_reg + TICK_W'(1);
                            idx_next   = '0;
                            state_next = ST_TICK;
                        end
                        OP_EXECUTE:
                        begin
                            if (ready_reg)
                            begin
                                // tasks beyond one run stay due and keep the flag up
                                ready_next = (int'(due_total) > RUN_CAP);
                                if (due_total != '0)
                                begin
                                    picks_next = (int'(due_total) > RUN_CAP)
                                                 ? CNT_W'(RUN_CAP) : due_total;
                                    idx_next   = '0;
                                    n_next     = '0;
                                    state_next = ST_EXEC;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SCHED:
            begin
                ram_wr_en          = 1'b1;
                used_next[sel_reg] = 1'b1;
                due_next[sel_reg]  = 1'b0;
                pend_slot_next     = HANDLE_W'(sel_reg);
                state_next         = ST_EMIT;
            end

            ST_CHECK:
            begin
                ram_rd_addr    = sel_reg;
                pend_slot_next = HANDLE_W'(sel_reg);
                state_next     = ST_EMIT;
                if (!used_reg[sel_reg] || (ram_rd_data.ident != ident_reg))
                begin
                    pend_status_next = STS_MISMATCH;
                end
                else
                begin
                    pend_status_next  = STS_OK;
                    due_next[sel_reg] = 1'b0;
                    if (op_reg == OP_RESCHEDULE)
                    begin
                        ram_wr_en = 1'b1;
                    end
                    else
                    begin
                        used_next[sel_reg] = 1'b0;
                    end
                end
            end

            ST_TICK:
            begin
                // read slot idx while slot idx-1 is compared and written back
                if (int'(idx_reg) < SLOTS)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx;
                    idx_next       = idx_reg + CNT_W'(1);
                end
                else if (!chk_valid_reg)
                begin
                    state_next = ST_EMIT;
                end
                if (tick_hit)
                begin
                    ram_wr_en              = 1'b1;
                    ram_wr_addr            = chk_idx_reg;
                    ram_wr_data            = '{ident: ram_rd_data.ident,
                                               interval: ram_rd_data.interval,
                                               deadline: tick_reg
                                                   + TICK_W'(ram_rd_data.interval)};
                    due_next[chk_idx_reg]  = 1'b1;
                    ready_next             = 1'b1;
                end
            end

            ST_EXEC:
            begin
                if (due_mask[scan_idx])
                begin
                    state_next = ST_EXEC_OUT;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            ST_EXEC_OUT:
            begin
                if (out_free)
                begin
                    out_load           = 1'b1;
                    out_valid_next     = 1'b1;
                    res_slot           = HANDLE_W'(scan_idx);
                    res_ident          = ram_rd_data.ident;
                    res_dv             = 1'b1;
                    res_last           = ((n_reg + CNT_W'(1)) == picks_reg);
                    due_next[scan_idx] = 1'b0;
                    n_next             = n_reg + CNT_W'(1);
                    idx_next           = idx_reg + CNT_W'(1);
                    state_next         = res_last ? ST_IDLE : ST_EXEC;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    res_status     = pend_status_reg;
                    res_slot       = pend_slot_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            n_reg         <= '0;
            picks_reg     <= '0;
            used_reg      <= '0;
            due_reg       <= '0;
            tick_reg      <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            n_reg         <= n_next;
            picks_reg     <= picks_next;
            used_reg      <= used_next;
            due_reg       <= due_next;
            tick_reg      <= tick_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg         <= sel_next;
        chk_idx_reg     <= chk_idx_next;
        pend_status_reg <= pend_status_next;
        pend_slot_reg   <= pend_slot_next;
        if (accept)
        begin
            op_reg    <= s_axis_tuser;
            ident_reg <= in_ident;
            prod_reg  <= prod_full;
        end
        if (out_load)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_slot;
            out_ident_reg  <= res_ident;
            out_dv_reg     <= res_dv;
            out_ready_reg  <= ready_reg;
            out_last_reg   <= res_last;
        end
    end

    ptst_ram #(
        .WIDTH ($bits(slot_entry_t)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_ready_reg, out_ident_reg, out_slot_reg, out_status_reg};
    assign m_axis_tuser  = out_dv_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ptst_ram.sv
// ----------------------------------------------------------------------------
// ptst_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module ptst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ptst_checker.sv
// ----------------------------------------------------------------------------
// ptst_checker
// port-level checks on the request and response streams of the slot table
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ptst_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [ptst_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                           m_axis_tuser,
    input wire logic                           m_axis_tlast
);

    import ptst_pkg::*;

    logic                rsp_stall;
    logic                rsp_plain;
    logic [STATUS_W-1:0] rsp_status;
    logic [IDENT_W-1:0]  rsp_ident;
    logic                req_taken;

    assign rsp_stall  = m_axis_tvalid && !m_axis_tready;
    assign rsp_plain  = m_axis_tvalid && !m_axis_tuser;
    assign rsp_status = m_axis_tdata[1:0];
    assign rsp_ident  = m_axis_tdata[21:6];
    assign req_taken  = s_axis_tvalid && s_axis_tready;

    // a stalled response stays offered
    `ASSERT_NEXT(a_rsp_held, clk, rst_n, rsp_stall, m_axis_tvalid)

    // one request in work at a time
    `ASSERT_NEXT(a_one_request, clk, rst_n, req_taken, !s_axis_tready)

    // a response without a due task closes its run and carries no identifier
    `ASSERT_IMPLY(a_plain_last, clk, rst_n, rsp_plain, m_axis_tlast && (rsp_ident == '0))

    // a failed request never reports a due task
    `ASSERT_IMPLY(a_fail_plain, clk, rst_n,
                  m_axis_tvalid && (rsp_status != STS_OK), !m_axis_tuser && m_axis_tlast)

    // status only takes its three defined codes
    `ASSERT_IMPLY(a_status_code, clk, rst_n, m_axis_tvalid,
                  (rsp_status == STS_OK) || (rsp_status == STS_FULL)
                  || (rsp_status == STS_MISMATCH))

endmodule

bind periodic_task_slot_table ptst_checker u_ptst_checker (.*);

`default_nettype wire
